// ----- src/bspg_pkg.sv -----
// Package for the bounded stepper pulse generator.
// Holds controller states, command/status structs and shared constants.
// No dependencies.
package bspg_pkg;

  // divider geometry: dividend/quotient and divisor widths
  localparam int unsigned DivW  = 34;
  localparam int unsigned DvsrW = 24;

  // configuration register indexes
  localparam logic [2:0] CfgIntervalMax = 3'd0;
  localparam logic [2:0] CfgIntervalMin = 3'd1;
  localparam logic [2:0] CfgTickPeriod  = 3'd2;
  localparam logic [2:0] CfgMaxPosition = 3'd3;
  localparam logic [2:0] CfgMaxAngle    = 3'd4;

  // configuration reset values
  localparam logic [15:0] RstIntervalMax = 16'd2000;
  localparam logic [15:0] RstIntervalMin = 16'd200;
  localparam logic [9:0]  RstTickPeriod  = 10'd20;
  localparam logic [23:0] RstMaxPosition = 24'd3200;
  localparam logic [8:0]  RstMaxAngle    = 9'd360;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IV_MUL,
    ST_IV_RECIP,
    ST_IV_LOAD,
    ST_UPDATE,
    ST_DEG_MUL,
    ST_DEG_START,
    ST_DEG_WAIT,
    ST_DONE
  } bspg_state_e;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic iv_mul;
    logic iv_recip;
    logic iv_load;
    logic div_start;
    logic update;
    logic deg_mul;
    logic deg_load;
    logic out_load;
  } bspg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_full;
  } bspg_stat_t;

endpackage

// ----- src/bspg_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bspg_pkg for the operand widths.
module bspg_div import bspg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [DvsrW-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DivW-1:0]  quot_o
);

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0]  dvd_q, dvd_d;
  logic [DvsrW-1:0] dvsr_q;
  logic [DvsrW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DvsrW:0]   shifted;
  logic [DvsrW+1:0] trial;
  logic             ge;

  // one shift-subtract step
  always_comb begin
    shifted = {rem_q, dvd_q[DivW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvsr_q};
    ge      = ~trial[DvsrW+1];
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial[DvsrW-1:0] : shifted[DvsrW-1:0];
      dvd_d = {dvd_q[DivW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (start_i) begin
      dvsr_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ----- src/bspg_ctrl.sv -----
// Controller state machine for the stepper pulse generator.
// Depends on bspg_pkg for states and the command/status structs.
module bspg_ctrl import bspg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_func_i,
  output logic       in_ready_o,
  input  bspg_stat_t stat_i,
  output bspg_cmd_t  cmd_o
);

  bspg_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_func_i ? ST_UPDATE : ST_IV_MUL;
        end
      end
      ST_IV_MUL:    state_d = ST_IV_RECIP;
      ST_IV_RECIP:  state_d = ST_IV_LOAD;
      ST_IV_LOAD:   state_d = ST_UPDATE;
      ST_UPDATE:    state_d = ST_DEG_MUL;
      ST_DEG_MUL:   state_d = ST_DEG_START;
      ST_DEG_START: state_d = ST_DEG_WAIT;
      ST_DEG_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ST_IV_MUL:    cmd_o.iv_mul    = 1'b1;
      ST_IV_RECIP:  cmd_o.iv_recip  = 1'b1;
      ST_IV_LOAD:   cmd_o.iv_load   = 1'b1;
      ST_UPDATE:    cmd_o.update    = 1'b1;
      ST_DEG_MUL:   cmd_o.deg_mul   = 1'b1;
      ST_DEG_START: cmd_o.div_start = 1'b1;
      ST_DEG_WAIT:  cmd_o.deg_load  = stat_i.div_done;
      ST_DONE:      cmd_o.out_load  = ~stat_i.out_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // divider is never restarted mid-division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !stat_i.div_busy)
    else $error("divider started while busy");

  // a result is never written over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !stat_i.out_full)
    else $error("result register overwritten");

  // a division ends only while the controller waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == ST_DEG_WAIT))
    else $error("unexpected divider completion");

  // a start is followed by a busy divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> stat_i.div_busy)
    else $error("divider did not start");

endmodule

// ----- src/bspg_dp.sv -----
// Datapath: configuration, motor state, interval and degree arithmetic.
// Depends on bspg_pkg and bspg_div.
module bspg_dp import bspg_pkg::*; #(
  parameter int unsigned DIAL_RANGE = 100
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bspg_cmd_t         cmd_i,
  output bspg_stat_t        stat_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [23:0]       cfg_wdata_i,
  input  logic              in_func_i,
  input  logic signed [7:0] in_dial_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_step_level_o,
  output logic              out_dir_level_o,
  output logic              out_moving_o,
  output logic [23:0]       out_position_steps_o,
  output logic [8:0]        out_position_degrees_o
);

  localparam int unsigned SatMag = (DIAL_RANGE < 128) ? DIAL_RANGE : 128;
  localparam logic [7:0]  SatMagW  = 8'(SatMag);

  // reciprocal of DIAL_RANGE-1, exact for span magnitudes below 2^IvAbsW
  localparam int unsigned IvAbsW     = 23;
  localparam int unsigned DialDiv    = DIAL_RANGE - 1;
  localparam int unsigned RecipShift = IvAbsW + $clog2(DialDiv);
  localparam logic [24:0] RecipMul   =
    25'(((64'd1 << RecipShift) + 64'(DialDiv) - 64'd1) / 64'(DialDiv));

  // configuration registers
  logic [15:0] ivmax_q, ivmin_q;
  logic [9:0]  tick_q;
  logic [23:0] maxpos_q;
  logic [8:0]  maxang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivmax_q  <= RstIntervalMax;
      ivmin_q  <= RstIntervalMin;
      tick_q   <= RstTickPeriod;
      maxpos_q <= RstMaxPosition;
      maxang_q <= RstMaxAngle;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIntervalMax: ivmax_q  <= cfg_wdata_i[15:0];
        CfgIntervalMin: ivmin_q  <= cfg_wdata_i[15:0];
        CfgTickPeriod:  tick_q   <= cfg_wdata_i[9:0];
        CfgMaxPosition: maxpos_q <= cfg_wdata_i;
        CfgMaxAngle:    maxang_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // latched input transaction
  logic              func_q;
  logic signed [7:0] dial_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= in_func_i;
      dial_q <= in_dial_i;
    end
  end

  // motor state registers
  logic [23:0] pos_q, pos_d;
  logic        dir_q, dir_d;
  logic [15:0] tgt_q, tgt_d;
  logic        en_q, en_d;
  logic [15:0] cnt_q, cnt_d;
  logic        pulse_q, pulse_d;
  logic        want, want_dir;
  logic [23:0] pos_step;
  logic        at_limit;

  // dial magnitude, saturated
  logic [7:0] mag, mag_sat, mag_m1;
  logic signed [16:0] iv_diff;
  logic signed [25:0] iv_prod;

  always_comb begin
    mag     = dial_q[7] ? 8'(-dial_q) : 8'(dial_q);
    mag_sat = (mag > SatMagW) ? SatMagW : mag;
    mag_m1  = mag_sat - 8'd1;
    iv_diff = $signed({1'b0, ivmin_q}) - $signed({1'b0, ivmax_q});
    iv_prod = $signed({1'b0, mag_m1}) * iv_diff;
  end

  logic signed [25:0] iv_prod_q;
  logic [32:0]        deg_prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.iv_mul) begin
      iv_prod_q <= iv_prod;
    end
    if (cmd_i.deg_mul) begin
      deg_prod_q <= 33'(pos_q) * 33'(maxang_q);
    end
  end

  // interval quotient by reciprocal multiply on the span magnitude
  logic [IvAbsW-1:0] iv_abs;
  logic [47:0]       recip_q;

  assign iv_abs = iv_prod_q[25] ? IvAbsW'(-iv_prod_q) : IvAbsW'(iv_prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.iv_recip) begin
      recip_q <= 48'(iv_abs) * 48'(RecipMul);
    end
  end

  // degree divider
  logic [DivW-1:0]   div_dividend;
  logic [DvsrW-1:0]  div_divisor;
  logic              div_busy, div_done;
  logic [DivW-1:0]   div_quot;

  assign div_dividend = DivW'(deg_prod_q) + DivW'(maxpos_q >> 1);
  assign div_divisor  = maxpos_q;

  bspg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // interval and degree results
  logic [15:0] iv_q;
  logic [8:0]  deg_q;
  logic [16:0] iv_quo, iv_new;
  logic [8:0]  deg_new;

  always_comb begin
    iv_quo = 17'(recip_q >> RecipShift);
    iv_new = {1'b0, ivmax_q} + (iv_prod_q[25] ? -iv_quo : iv_quo);
    if (maxpos_q == '0) begin
      deg_new = '0;
    end else if (div_quot > DivW'(511)) begin
      deg_new = 9'd511;
    end else begin
      deg_new = div_quot[8:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.iv_load) begin
      iv_q <= iv_new[15:0];
    end
    if (cmd_i.deg_load) begin
      deg_q <= deg_new;
    end
  end

  // motor state
  always_comb begin
    pos_d    = pos_q;
    dir_d    = dir_q;
    tgt_d    = tgt_q;
    en_d     = en_q;
    cnt_d    = cnt_q;
    pulse_d  = pulse_q;
    pos_step = dir_q ? pos_q + 24'd1 : pos_q - 24'd1;
    at_limit = dir_q ? (pos_q >= maxpos_q) : (pos_q == '0);
    want_dir = ~dial_q[7] && (dial_q != '0);
    want     = (dial_q != '0);
    if (want_dir && (pos_q >= maxpos_q)) begin
      want = 1'b0;
    end
    if (!want_dir && (pos_q == '0)) begin
      want = 1'b0;
    end
    if (func_q) begin
      // timer tick
      if (pulse_q) begin
        pulse_d = 1'b0;
        pos_d   = pos_step;
        cnt_d   = tgt_q;
      end else if (en_q && !at_limit) begin
        if (cnt_q <= {6'd0, tick_q}) begin
          pulse_d = 1'b1;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q - {6'd0, tick_q};
        end
      end
    end else begin
      // dial update
      if (!want) begin
        en_d = 1'b0;
      end else begin
        if (want_dir != dir_q) begin
          if (pulse_q) begin
            pulse_d = 1'b0;
            pos_d   = pos_step;
          end
          dir_d = want_dir;
          cnt_d = iv_q;
        end
        tgt_d = iv_q;
        en_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      dir_q   <= 1'b1;
      tgt_q   <= RstIntervalMax;
      en_q    <= 1'b0;
      cnt_q   <= '0;
      pulse_q <= 1'b0;
    end else if (cmd_i.update) begin
      pos_q   <= pos_d;
      dir_q   <= dir_d;
      tgt_q   <= tgt_d;
      en_q    <= en_d;
      cnt_q   <= cnt_d;
      pulse_q <= pulse_d;
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_step_level_o       <= pulse_q;
      out_dir_level_o        <= dir_q;
      out_moving_o           <= en_q;
      out_position_steps_o   <= pos_q;
      out_position_degrees_o <= deg_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.div_busy = div_busy;
  assign stat_o.div_done = div_done;
  assign stat_o.out_full = out_valid_q & ~out_ready_i;

endmodule

// ----- src/bounded_stepper_pulse_generator_unit.sv -----
// Step/direction pulse generator with soft travel limits.
// A dial transaction passes interval multiply, reciprocal and interval load, then the
// motor update, degree multiply and bit-serial divider for the degree scaling; a tick
// transaction skips the interval steps. One is in work at a time, so the input takes
// no new transaction until the last result has gone into the output register.
// Reset: asynchronous; motor state and configuration return to their defaults.
module bounded_stepper_pulse_generator_unit import bspg_pkg::*; #(
  parameter int unsigned DIAL_RANGE = 100
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [23:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_func_i,
  input  logic signed [7:0] in_dial_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_step_level_o,
  output logic              out_dir_level_o,
  output logic              out_moving_o,
  output logic [23:0]       out_position_steps_o,
  output logic [8:0]        out_position_degrees_o
);

  bspg_cmd_t  cmd;
  bspg_stat_t stat;

  bspg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_func_i (in_func_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bspg_dp #(
    .DIAL_RANGE(DIAL_RANGE)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_func_i             (in_func_i),
    .in_dial_i             (in_dial_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .out_step_level_o      (out_step_level_o),
    .out_dir_level_o       (out_dir_level_o),
    .out_moving_o          (out_moving_o),
    .out_position_steps_o  (out_position_steps_o),
    .out_position_degrees_o(out_position_degrees_o)
  );

endmodule
